### hdl/assert_macros.svh
// Assertion macros shared by the set table RTL.
// Expects clk_i in the scope of every use, and rst_ni for ASSERT_RST.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge, reset included.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

// Check on every rising edge outside reset.
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`endif

### hdl/oist_pkg.sv
// Types and codes of the ordered integer set table.
// No dependencies; used by oist_cell and the top level.
`timescale 1ns / 1ps

package oist_pkg;

  typedef enum logic [2:0] {
    MODE_INSERT = 3'd0,
    MODE_REMOVE = 3'd1,
    MODE_EXISTS = 3'd2,
    MODE_FIRST  = 3'd3,
    MODE_NEXT   = 3'd4
  } oist_mode_e;

  typedef struct packed {
    logic [2:0]   mode;
    logic [31:0]  value;
  } oist_req_t;

  typedef struct packed {
    logic         present;
    logic         item_valid;
    logic [31:0]  item;
    logic         overflow;
    logic [4:0]   entry_count;
    logic         is_empty;
  } oist_res_t;

  // Per-cell update controls.
  typedef struct packed {
    logic append;   // load the key into this cell
    logic remove;   // a remove hit somewhere in the table
  } oist_cell_ctrl_t;

endpackage

### hdl/oist_cell.sv
// One cell of the set table chain: holds one entry, compares it with the key
// and takes its upper neighbor's entry on a remove. Depends on oist_pkg.
`timescale 1ns / 1ps

module oist_cell (
  input  logic                      clk_i,
  input  oist_pkg::oist_cell_ctrl_t ctrl_i,
  input  logic [31:0]               key_i,
  input  logic                      live_i,
  input  logic [31:0]               upper_i,
  input  logic                      chain_i,
  output logic [31:0]               entry_o,
  output logic                      hit_o,
  output logic                      chain_o
);

  logic [31:0] entry_q, entry_d;

  assign entry_o = entry_q;
  assign hit_o   = live_i && (entry_q == key_i);
  // A hit at or below this cell means this cell closes the gap.
  assign chain_o = chain_i || hit_o;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.append) begin
      entry_d = key_i;
    end else if (ctrl_i.remove && chain_o) begin
      entry_d = upper_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

### hdl/ordered_integer_set_table_unit.sv
// Top level of the ordered integer set table: a chain of oist_cell entries
// with count, walk position and the result register. Depends on oist_pkg,
// oist_cell and assert_macros.svh.
`timescale 1ns / 1ps

//  channel   | ports                     | handshake
//  ----------+---------------------------+------------------------------------
//  request   | req_i (mode, value)       | taken when start_i high, busy_o low
//  result    | res_o (present .. empty)  | valid for one cycle while done_o
//
//  Each result is registered: the item is taken at an edge and its
//  result is on res_o with done_o in the cycle after it.
//  busy_o stays low, so a new item may be taken every cycle; the compare
//  across all cells and the remove shift both finish within that cycle.
//  The receiver cannot stall; each result is shown exactly once.
//  Reset clears the count, the walk position and the strobe; the entries
//  themselves hold whatever they held until written.

`include "assert_macros.svh"

module ordered_integer_set_table_unit #(
  parameter int CAPACITY = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  oist_pkg::oist_req_t req_i,
  output logic                busy_o,
  output logic                done_o,
  output oist_pkg::oist_res_t res_o
);

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int IdxW = $clog2(CAPACITY);

  logic [CntW-1:0] occ_q, occ_d;
  logic [CntW-1:0] walk_q, walk_d;
  logic            done_q;
  oist_pkg::oist_res_t res_q, res_d;

  logic [31:0]     entry_w [CAPACITY];
  logic [CAPACITY-1:0] hit_w;
  logic [CAPACITY:0]   chain_w;
  logic [CAPACITY-1:0] live_w;

  logic            accept;
  logic            found;
  logic            is_full;
  logic            do_append;
  logic            do_remove;
  logic [IdxW-1:0] sel_idx;
  logic [31:0]     sel_entry;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign found  = |hit_w;
  assign is_full = (occ_q == CntW'(CAPACITY));

  assign do_append = accept && (req_i.mode == oist_pkg::MODE_INSERT) && !found && !is_full;
  assign do_remove = accept && (req_i.mode == oist_pkg::MODE_REMOVE) && found;

  // Read port for first / next: first always reads the bottom cell.
  assign sel_idx   = (req_i.mode == oist_pkg::MODE_FIRST) ? '0 : walk_q[IdxW-1:0];
  assign sel_entry = entry_w[sel_idx];

  assign chain_w[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    oist_pkg::oist_cell_ctrl_t ctrl;
    logic [31:0]               upper;

    assign live_w[i]   = (CntW'(i) < occ_q);
    assign ctrl.append = do_append && (occ_q == CntW'(i));
    assign ctrl.remove = do_remove;
    // Top cell has no neighbor above; its stale copy sits past the count.
    assign upper = (i == CAPACITY - 1) ? entry_w[i] : entry_w[(i + 1) % CAPACITY];

    oist_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .key_i   (req_i.value),
      .live_i  (live_w[i]),
      .upper_i (upper),
      .chain_i (chain_w[i]),
      .entry_o (entry_w[i]),
      .hit_o   (hit_w[i]),
      .chain_o (chain_w[i+1])
    );
  end

  // Work out the result and the next count and walk position.
  always_comb begin
    occ_d  = occ_q;
    walk_d = walk_q;
    res_d  = '0;
    case (req_i.mode)
      oist_pkg::MODE_INSERT: begin
        res_d.present  = found;
        res_d.overflow = !found && is_full;
        if (!found && !is_full) begin
          occ_d = occ_q + CntW'(1);
        end
      end
      oist_pkg::MODE_REMOVE: begin
        if (found) begin
          occ_d = occ_q - CntW'(1);
        end
        // Pull the walk back so that a next reads the second entry.
        if (walk_q > CntW'(1)) begin
          walk_d = CntW'(1);
        end
      end
      oist_pkg::MODE_EXISTS: begin
        res_d.present = found;
      end
      oist_pkg::MODE_FIRST: begin
        if (occ_q != '0) begin
          walk_d           = CntW'(1);
          res_d.item_valid = 1'b1;
          res_d.item       = sel_entry;
        end
      end
      oist_pkg::MODE_NEXT: begin
        if (walk_q < occ_q) begin
          walk_d           = walk_q + CntW'(1);
          res_d.item_valid = 1'b1;
          res_d.item       = sel_entry;
        end
      end
      default: begin
        // Unused modes: report the count only.
      end
    endcase
    res_d.entry_count = 5'(occ_d);
    res_d.is_empty    = (occ_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q  <= '0;
      walk_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        occ_q  <= occ_d;
        walk_q <= walk_d;
      end
    end
  end

  // Hold the result payload; done_q marks its one valid cycle.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  `ASSERT_CLK(a_occ_bound, occ_q <= CntW'(CAPACITY), "entry count above capacity")
  `ASSERT_RST(a_single_hit, $onehot0(hit_w), "key matches more than one entry")
  `ASSERT_RST(a_chain_found, chain_w[CAPACITY] == found, "hit chain disagrees with match")
  `ASSERT_RST(a_done_follows, accept |=> done_o, "accepted item gave no result")
  `ASSERT_RST(a_ovf_full, accept && res_d.overflow |-> is_full, "overflow below capacity")
  `ASSERT_RST(a_walk_bound, done_o && res_o.item_valid |-> walk_q <= occ_q, "walk ran past the count")

endmodule

### tb/sv/tb_top.sv
// Self-checking bench for ordered_integer_set_table_unit: directed table, then random traffic.
// Depends on oist_pkg and the RTL; checks results with its own model or a typed expectation.
`timescale 1ns / 1ps

module tb_top;

  localparam int          CAPACITY       = 16;
  localparam int          RAND_ITEMS     = 500;
  localparam int          PHASE_LEN      = 40;   // items per grow or shrink phase
  localparam int          CALM_FIRST     = 150;  // random items in this range never idle
  localparam int          CALM_LAST      = 280;
  localparam int          IDLE_PCT       = 26;
  localparam int          POOL_SIZE      = 24;
  localparam int          DRAIN_CYCLES   = 8;
  localparam int          STALL_LIMIT    = 1000;
  localparam logic [2:0]  MODE_UNUSED_LO = 3'd5;
  localparam logic [2:0]  MODE_UNUSED_HI = 3'd7;
  localparam logic [31:0] INT_MIN        = 32'h8000_0000;
  localparam logic [31:0] INT_MAX        = 32'h7FFF_FFFF;

  typedef struct {
    logic [2:0]          mode;
    logic [31:0]         value;
    int                  reps;    // repeat with value, value+1, ...
    bit                  fixed;   // compare against res instead of the predictor
    oist_pkg::oist_res_t res;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  oist_pkg::oist_req_t req_i;
  logic                busy_o;
  logic                done_o;
  oist_pkg::oist_res_t res_o;

  // Typed expectation that travels with the item on req_i.
  bit                  fixed_q;
  oist_pkg::oist_res_t fixed_res_q;

  // Predictor state: entries in insertion order, count and walk position.
  logic [31:0] set_entries [CAPACITY];
  int          set_count = 0;
  int          walk_pos  = 0;

  oist_pkg::oist_res_t results_due [$];
  stim_row_t           dir_rows [$];
  logic [31:0]         value_pool [POOL_SIZE];
  int                  mismatch_cnt = 0;
  int                  quiet_cycles = 0;

  ordered_integer_set_table_unit #(.CAPACITY(CAPACITY)) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .req_i   (req_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .res_o   (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic oist_pkg::oist_res_t res_of(int p, int iv, logic [31:0] it, int ov,
                                                 int cnt, int emp);
    oist_pkg::oist_res_t r;
    r.present     = 1'(p);
    r.item_valid  = 1'(iv);
    r.item        = it;
    r.overflow    = 1'(ov);
    r.entry_count = 5'(cnt);
    r.is_empty    = 1'(emp);
    return r;
  endfunction

  // Apply one operation to the predictor state and return the result it causes.
  function automatic oist_pkg::oist_res_t set_apply(oist_pkg::oist_req_t rq);
    oist_pkg::oist_res_t r;
    int                  slot;
    r    = '0;
    slot = -1;
    for (int i = 0; i < set_count; i++)
      if (slot < 0 && set_entries[i] == rq.value) slot = i;
    case (rq.mode)
      oist_pkg::MODE_INSERT: begin
        if (slot >= 0) begin
          r.present = 1'b1;
        end else if (set_count >= CAPACITY) begin
          r.overflow = 1'b1;
        end else begin
          set_entries[set_count] = rq.value;
          set_count++;
        end
      end
      oist_pkg::MODE_REMOVE: begin
        if (slot >= 0) begin
          // shift later entries down over the hit
          for (int i = slot; i + 1 < set_count; i++) set_entries[i] = set_entries[i + 1];
          set_count--;
        end
        // any remove pulls a walk in progress back to the second entry
        if (walk_pos > 1) walk_pos = 1;
      end
      oist_pkg::MODE_EXISTS: r.present = (slot >= 0);
      oist_pkg::MODE_FIRST: begin
        if (set_count > 0) begin
          walk_pos     = 1;
          r.item_valid = 1'b1;
          r.item       = set_entries[0];
        end
      end
      oist_pkg::MODE_NEXT: begin
        if (walk_pos < set_count) begin
          r.item_valid = 1'b1;
          r.item       = set_entries[walk_pos];
          walk_pos++;
        end
      end
      default: ;  // unused modes change nothing
    endcase
    r.entry_count = 5'(set_count);
    r.is_empty    = (set_count == 0);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  task automatic check_result(oist_pkg::oist_res_t want, oist_pkg::oist_res_t got);
    check_field("present",     32'(want.present),     32'(got.present));
    check_field("item_valid",  32'(want.item_valid),  32'(got.item_valid));
    check_field("item",        want.item,             got.item);
    check_field("overflow",    32'(want.overflow),    32'(got.overflow));
    check_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
    check_field("is_empty",    32'(want.is_empty),    32'(got.is_empty));
  endtask

  function automatic void add_row(logic [2:0] m, logic [31:0] v, int reps, bit fx,
                                  oist_pkg::oist_res_t r);
    stim_row_t row;
    row.mode  = m;
    row.value = v;
    row.reps  = reps;
    row.fixed = fx;
    row.res   = r;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  // Grow phases favor inserts so the table fills up; shrink phases drain it.
  function automatic logic [2:0] pick_mode(bit grow);
    int roll;
    roll = $urandom_range(99);
    if (roll < (grow ? 55 : 15)) return oist_pkg::MODE_INSERT;
    if (roll < (grow ? 65 : 50)) return oist_pkg::MODE_REMOVE;
    if (roll < 72) return oist_pkg::MODE_EXISTS;
    if (roll < 80) return oist_pkg::MODE_FIRST;
    if (roll < 95) return oist_pkg::MODE_NEXT;
    return 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
  endfunction

  // Mostly draw from a small pool so inserts, removes and lookups hit each other.
  function automatic logic [31:0] pick_value();
    if ($urandom_range(99) < 85) return value_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom;
  endfunction

  // Present one item, optionally after random idle cycles; return once it is taken.
  task automatic send_item(logic [2:0] m, logic [31:0] v, bit fx, oist_pkg::oist_res_t fr,
                           bit may_idle);
    while (may_idle && $urandom_range(99) < IDLE_PCT) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i     <= 1'b1;
    req_i       <= '{mode: m, value: v};
    fixed_q     <= fx;
    fixed_res_q <= fr;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Monitor: predict on every accepted item, check every strobed result, watch for hangs.
  always @(posedge clk_i) begin
    oist_pkg::oist_res_t want;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        // always advance the predictor, even when a typed expectation wins
        want = set_apply(req_i);
        if (fixed_q) want = fixed_res_q;
        results_due.insert(results_due.size(), want);
      end
      if (done_o) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %p", $time, res_o);
          mismatch_cnt++;
        end else begin
          check_result(results_due.pop_front(), res_o);
        end
      end
      if ((start_i && !busy_o) || done_o) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  initial begin
    bit grow;
    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    req_i       <= '0;
    fixed_q     <= 1'b0;
    fixed_res_q <= '0;

    value_pool[0] = INT_MIN;
    value_pool[1] = INT_MAX;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;

    // Empty set: walks end at once, removes miss, unused modes report count only.
    add_row(oist_pkg::MODE_FIRST,  32'd0,  1, 1'b1, res_of(0, 0, 0, 0, 0, 1));
    add_row(oist_pkg::MODE_NEXT,   32'd0,  1, 1'b1, res_of(0, 0, 0, 0, 0, 1));
    add_row(oist_pkg::MODE_REMOVE, 32'd5,  1, 1'b1, res_of(0, 0, 0, 0, 0, 1));
    add_row(oist_pkg::MODE_EXISTS, INT_MIN, 1, 1'b1, res_of(0, 0, 0, 0, 0, 1));
    add_row(MODE_UNUSED_LO,        32'hFFFF_FFFF, 1, 1'b1, res_of(0, 0, 0, 0, 0, 1));
    add_row(MODE_UNUSED_HI,        32'd0,  1, 1'b1, res_of(0, 0, 0, 0, 0, 1));
    // Extremes, duplicate insert, lookup.
    add_row(oist_pkg::MODE_INSERT, INT_MIN, 1, 1'b1, res_of(0, 0, 0, 0, 1, 0));
    add_row(oist_pkg::MODE_INSERT, INT_MAX, 1, 1'b1, res_of(0, 0, 0, 0, 2, 0));
    add_row(oist_pkg::MODE_INSERT, INT_MIN, 1, 1'b1, res_of(1, 0, 0, 0, 2, 0));
    add_row(oist_pkg::MODE_EXISTS, INT_MAX, 1, 1'b1, res_of(1, 0, 0, 0, 2, 0));
    // Next with no walk started gives the first entry, then the second, then runs off the end.
    add_row(oist_pkg::MODE_NEXT,   32'd0,  1, 1'b1, res_of(0, 1, INT_MIN, 0, 2, 0));
    add_row(oist_pkg::MODE_NEXT,   32'd0,  1, 1'b1, res_of(0, 1, INT_MAX, 0, 2, 0));
    add_row(oist_pkg::MODE_NEXT,   32'd0,  1, 1'b1, res_of(0, 0, 0, 0, 2, 0));
    add_row(oist_pkg::MODE_FIRST,  32'd0,  1, 1'b1, res_of(0, 1, INT_MIN, 0, 2, 0));
    // Fill to capacity, then overflow; a duplicate on a full table is still present.
    add_row(oist_pkg::MODE_INSERT, 32'd1, 14, 1'b0, '0);
    add_row(oist_pkg::MODE_INSERT, 32'h1234_5678, 1, 1'b1, res_of(0, 0, 0, 1, 16, 0));
    add_row(oist_pkg::MODE_INSERT, INT_MAX, 1, 1'b1, res_of(1, 0, 0, 0, 16, 0));
    // Remove during a walk, hit and miss, pulls the walk back.
    add_row(oist_pkg::MODE_NEXT,   32'd0,  2, 1'b0, '0);
    add_row(oist_pkg::MODE_REMOVE, INT_MIN, 1, 1'b0, '0);
    add_row(oist_pkg::MODE_NEXT,   32'd0,  2, 1'b0, '0);
    add_row(oist_pkg::MODE_REMOVE, 32'h5555_5555, 1, 1'b0, '0);
    add_row(oist_pkg::MODE_NEXT,   32'd0,  1, 1'b0, '0);
    add_row(oist_pkg::MODE_EXISTS, INT_MAX, 1, 1'b0, '0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r])
      for (int k = 0; k < dir_rows[r].reps; k++)
        send_item(dir_rows[r].mode, dir_rows[r].value + k, dir_rows[r].fixed,
                  dir_rows[r].res, 1'b1);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      grow = ((n / PHASE_LEN) % 2) == 0;
      send_item(pick_mode(grow), pick_value(), 1'b0, '0,
                !(n >= CALM_FIRST && n < CALM_LAST));
    end
    start_i <= 1'b0;

    // Drain: the watchdog bounds this wait, then keep watching for strays.
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0 && results_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/oist_pkg.sv
hdl/oist_cell.sv
hdl/ordered_integer_set_table_unit.sv
tb/sv/tb_top.sv
